FILE: src/bf33_pkg.sv
// shared constants and types for the 3x3 box filter
// no dependencies
package bf33_pkg;

   localparam int PIX_W = 8;
   localparam int COORD_W = 9;
   localparam int CFG_W = 10;
   localparam int SUM_W = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RSP_DATA_W = 32;

   localparam int DEF_MAX_WIDTH = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DIM_MIN = 3;

   localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;

   // floor(sum / 9) as (sum * 7282) >> 16, exact for sums up to 2295
   localparam int DIV9_RECIP_W = 13;
   localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP = 13'd7282;
   localparam int DIV9_SHIFT = 16;
   localparam int PROD_W = SUM_W + DIV9_RECIP_W;

   typedef enum logic {
      REG_LINE_WIDTH = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic done;
   } tag_type;

endpackage

FILE: src/bf33_line_buf.sv
// two line stores in synchronous memory with a registered read
// depends on bf33_pkg
module bf33_line_buf import bf33_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_pixel,
   output logic [PIX_W-1:0] top_pixel,
   output logic [PIX_W-1:0] mid_pixel
);

   logic [PIX_W-1:0] store_a [MAX_WIDTH];
   logic [PIX_W-1:0] store_b [MAX_WIDTH];
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;

   // line one above moves down to line two above
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a[wr_addr] <= wr_pixel;
         store_b[wr_addr] <= mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= store_b[rd_addr];
         mid_ff <= store_a[rd_addr];
      end
   end

   assign top_pixel = top_ff;
   assign mid_pixel = mid_ff;

endmodule

FILE: src/bf33_window.sv
// 3x3 window registers and the nine-term sum stage
// depends on bf33_pkg
module bf33_window import bf33_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_emit,
   input  tag_type in_tag,
   input  logic [PIX_W-1:0] in_top,
   input  logic [PIX_W-1:0] in_mid,
   input  logic [PIX_W-1:0] in_bot,
   output logic out_valid,
   input  logic out_ready,
   output logic [SUM_W-1:0] out_sum,
   output tag_type out_tag
);

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic win_v_ff;
   tag_type win_tag_ff;
   logic sum_v_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   tag_type sum_tag_ff;
   logic sum_adv;
   logic win_adv;
   logic in_fire;

   assign sum_adv = sum_v_ff && out_ready;
   assign win_adv = win_v_ff && (!sum_v_ff || sum_adv);
   assign in_ready = !win_v_ff || win_adv;
   assign in_fire = in_valid && in_ready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = in_top;
      win_in[5] = in_mid;
      win_in[8] = in_bot;
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 9; k++) begin
         sum_in = sum_in + SUM_W'(win_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
         win_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
      end else begin
         if (in_fire) begin
            win_ff <= win_in;
            win_v_ff <= in_emit;
         end else if (win_adv) begin
            win_v_ff <= 1'b0;
         end
         if (win_adv) begin
            sum_v_ff <= 1'b1;
         end else if (sum_adv) begin
            sum_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         win_tag_ff <= in_tag;
      end
      if (win_adv) begin
         sum_ff <= sum_in;
         sum_tag_ff <= win_tag_ff;
      end
   end

   assign out_valid = sum_v_ff;
   assign out_sum = sum_ff;
   assign out_tag = sum_tag_ff;

endmodule

FILE: src/bf33_div9.sv
// divide-by-nine through a constant reciprocal, and the output register
// depends on bf33_pkg
module bf33_div9 import bf33_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [SUM_W-1:0] in_sum,
   input  tag_type in_tag,
   output logic out_valid,
   input  logic out_ready,
   output logic [PIX_W-1:0] out_mean,
   output tag_type out_tag
);

   logic out_v_ff;
   logic [PIX_W-1:0] mean_ff;
   logic [PIX_W-1:0] mean_in;
   logic [PROD_W-1:0] prod;
   tag_type tag_ff;

   assign in_ready = !out_v_ff || out_ready;
   assign prod = PROD_W'(in_sum) * PROD_W'(DIV9_RECIP);
   assign mean_in = prod[DIV9_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (in_ready) begin
         out_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mean_ff <= mean_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = out_v_ff;
   assign out_mean = mean_ff;
   assign out_tag = tag_ff;

endmodule

FILE: src/box_filter_3x3_mean_core.sv
// top level of the 3x3 box (mean) filter: registers, raster counters, line stores
// depends on bf33_pkg, bf33_line_buf, bf33_window, bf33_div9
//
// req channel takes one 8-bit grayscale pixel per word in raster order.
// rsp channel gives one word per interior pixel (row and column both at least 1
// and below the last): floor of the 3x3 sum over nine, the centre's row and
// column, and tlast on the last interior pixel of the frame. Border pixels give
// no word.
// One pixel is accepted every cycle unless a low rsp_tready has filled the stages.
// Between acceptance and output, a pixel passes the line-store read, the window,
// the sum and the divide (output) registers in turn.
// The csr port sets line width and frame height (clamped to 3 .. maximum);
// any write restarts the frame at row 0, column 0. Write only while idle.
// Reset clears the window, counters and pipeline and sets both sizes to 512;
// line-store contents are unknown until the first two lines have passed.
// When rsp_tready is low, words back up through the stages and req_tready
// drops once all of them are full; nothing is lost.
module box_filter_3x3_mean_core import bf33_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [PIX_W-1:0] req_tdata,        // pixel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // mean_value, out_row, out_col
   output logic rsp_tlast,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int HDW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
   localparam int XW = (CW > COORD_W) ? CW : COORD_W;
   localparam int YW = (RW > COORD_W) ? RW : COORD_W;

   logic [CFG_W-1:0] line_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [WDW-1:0] w_eff;
   logic [HDW-1:0] h_eff;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;
   logic csr_write;
   reg_index_type csr_index;
   logic req_fire;
   logic emit;
   tag_type tag;

   logic s1_v_ff;
   logic s1_emit_ff;
   tag_type s1_tag_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   logic s1_fire;

   logic [PIX_W-1:0] top_pixel;
   logic [PIX_W-1:0] mid_pixel;
   logic win_ready;
   logic sum_valid;
   logic sum_ready;
   logic [SUM_W-1:0] sum;
   tag_type sum_tag;
   logic [PIX_W-1:0] mean;
   tag_type rsp_tag;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_index)
         REG_LINE_WIDTH:   csr_prdata = CSR_DATA_W'(line_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // effective frame size
   always_comb begin
      if (WDW'(line_width_ff) < WDW'(DIM_MIN)) begin
         w_eff = WDW'(DIM_MIN);
      end else if (WDW'(line_width_ff) > WDW'(MAX_WIDTH)) begin
         w_eff = WDW'(MAX_WIDTH);
      end else begin
         w_eff = WDW'(line_width_ff);
      end
      if (HDW'(frame_height_ff) < HDW'(DIM_MIN)) begin
         h_eff = HDW'(DIM_MIN);
      end else if (HDW'(frame_height_ff) > HDW'(MAX_HEIGHT)) begin
         h_eff = HDW'(MAX_HEIGHT);
      end else begin
         h_eff = HDW'(frame_height_ff);
      end
   end

   // raster position of the incoming pixel
   always_comb begin
      c_cur = col_ff;
      if (WDW'(col_ff) >= w_eff) begin
         c_cur = CW'(w_eff - WDW'(1));
      end
      r_cur = row_ff;
      if (HDW'(row_ff) >= h_eff) begin
         r_cur = RW'(h_eff - HDW'(1));
      end
      if (WDW'(c_cur) + WDW'(1) >= w_eff) begin
         col_in = '0;
         row_in = (HDW'(r_cur) + HDW'(1) >= h_eff) ? '0 : r_cur + RW'(1);
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
      emit = (c_cur >= CW'(2)) && (r_cur >= RW'(2));
      tag.row = COORD_W'(YW'(r_cur) - YW'(1));
      tag.col = COORD_W'(XW'(c_cur) - XW'(1));
      tag.done = (WDW'(c_cur) == w_eff - WDW'(1)) && (HDW'(r_cur) == h_eff - HDW'(1));
   end

   assign s1_fire = s1_v_ff && win_ready;
   assign req_tready = !s1_v_ff || win_ready;
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= CFG_RESET;
         frame_height_ff <= CFG_RESET;
         col_ff <= '0;
         row_ff <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_LINE_WIDTH:   line_width_ff <= csr_pwdata[CFG_W-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[CFG_W-1:0];
               default:          line_width_ff <= line_width_ff;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_fire) begin
            s1_v_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_emit_ff <= emit;
         s1_tag_ff <= tag;
         s1_pixel_ff <= req_tdata;
         s1_col_ff <= c_cur;
      end
   end

   bf33_line_buf #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_buf (
      .clock(clock),
      .rd_en(req_fire),
      .rd_addr(c_cur),
      .wr_en(s1_fire),
      .wr_addr(s1_col_ff),
      .wr_pixel(s1_pixel_ff),
      .top_pixel(top_pixel),
      .mid_pixel(mid_pixel)
   );

   bf33_window u_window (
      .clock(clock),
      .reset(reset),
      .in_valid(s1_v_ff),
      .in_ready(win_ready),
      .in_emit(s1_emit_ff),
      .in_tag(s1_tag_ff),
      .in_top(top_pixel),
      .in_mid(mid_pixel),
      .in_bot(s1_pixel_ff),
      .out_valid(sum_valid),
      .out_ready(sum_ready),
      .out_sum(sum),
      .out_tag(sum_tag)
   );

   bf33_div9 u_div9 (
      .clock(clock),
      .reset(reset),
      .in_valid(sum_valid),
      .in_ready(sum_ready),
      .in_sum(sum),
      .in_tag(sum_tag),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_mean(mean),
      .out_tag(rsp_tag)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_tag.col, rsp_tag.row, mean});
   assign rsp_tlast = rsp_tag.done;

endmodule
